// ===== hdl/vpn_pkg.sv =====
// Shared types, constants and the Tausworthe step function for the pink noise generator.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package vpn_pkg;

    localparam int NUM_DICE_DEF     = 32;
    localparam int COUNTER_BITS_DEF = 16;

    localparam int SAMPLE_W  = 32;
    localparam int WORD_W    = 32;
    localparam int DIE_SHIFT = 5;
    localparam int DIE_W     = WORD_W - DIE_SHIFT;
    localparam int MASK_W    = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [WORD_W-1:0] SEED_RESET = 32'd12345;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_BITS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_ONE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_TWO   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_THREE = 2'd3;

    typedef struct packed {
        logic [WORD_W-1:0] s1;
        logic [WORD_W-1:0] s2;
        logic [WORD_W-1:0] s3;
    } t_taus;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;     // latch full-redraw mode for a new sample
        logic issue;     // read die at the given index and queue it for processing
        logic load_out;  // capture the sample and advance the sample counter
    } t_ctrl_cmd;

    // One combined step of the three Tausworthe components.
    function automatic t_taus taus_step(input t_taus st);
        t_taus             nx;
        logic [WORD_W-1:0] b;
        b     = ((st.s1 << 13) ^ st.s1) >> 19;
        nx.s1 = ((st.s1 & 32'hFFFF_FFFE) << 12) ^ b;
        b     = ((st.s2 << 2) ^ st.s2) >> 25;
        nx.s2 = ((st.s2 & 32'hFFFF_FFF8) << 4) ^ b;
        b     = ((st.s3 << 3) ^ st.s3) >> 11;
        nx.s3 = ((st.s3 & 32'hFFFF_FFF0) << 17) ^ b;
        return nx;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/vpn_datapath.sv =====
// Datapath: generator words, dice memory, running sum, sample counter and output register.
// Depends on vpn_pkg; driven by commands from vpn_ctrl.
`default_nettype none

module vpn_datapath
    import vpn_pkg::*;
#(
    parameter int NUM_DICE     = NUM_DICE_DEF,
    parameter int COUNTER_BITS = COUNTER_BITS_DEF,
    parameter int IDX_W        = $clog2(NUM_DICE)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_ctrl_cmd            i_cmd,
    input  wire logic [IDX_W-1:0]     i_idx,
    input  wire logic                 i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [WORD_W-1:0]    i_cfg_data,
    output logic [SAMPLE_W-1:0]       o_sample
);

    t_taus                   r_rng, n_rng, taus_nx;
    logic [SAMPLE_W-1:0]     r_sum, n_sum;
    logic [COUNTER_BITS-1:0] r_counter;
    logic [MASK_W-1:0]       r_mask_bits;
    logic                    r_full;
    logic [SAMPLE_W-1:0]     r_sample;

    logic [DIE_W-1:0]        r_dice [NUM_DICE];
    logic [DIE_W-1:0]        r_rd_data;

    logic                    r_p_valid;
    logic                    r_p_sel;
    logic [IDX_W-1:0]        r_p_idx;

    logic [NUM_DICE-1:0]     sel_vec;
    logic                    do_draw;
    logic [DIE_W-1:0]        new_die;
    logic [SAMPLE_W-1:0]     old_die;
    logic [SAMPLE_W-1:0]     mask, offset;

    // Dice at or above the counter width are never selected; counter bits at or above the dice count select nothing.
    genvar g;
    generate
        for (g = 0; g < NUM_DICE; g++) begin : g_sel
            if (g < COUNTER_BITS) begin : g_bit
                assign sel_vec[g] = r_counter[g];
            end else begin : g_zero
                assign sel_vec[g] = 1'b0;
            end
        end
    endgenerate

    assign do_draw = r_p_valid && r_p_sel;
    assign taus_nx = taus_step(r_rng);
    assign new_die = DIE_W'((taus_nx.s1 ^ taus_nx.s2 ^ taus_nx.s3) >> DIE_SHIFT);
    assign old_die = r_full ? '0 : {{(SAMPLE_W-DIE_W){1'b0}}, r_rd_data};

    always_comb begin
        n_rng = r_rng;
        n_sum = r_sum;
        if (do_draw) begin
            n_rng = taus_nx;
            n_sum = r_sum - old_die + {{(SAMPLE_W-DIE_W){1'b0}}, new_die};
        end else if (i_cmd.start && r_counter == '0) begin
            n_sum = '0;
        end
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SEED_ONE:   n_rng.s1 = i_cfg_data;
                CFG_SEED_TWO:   n_rng.s2 = i_cfg_data;
                CFG_SEED_THREE: n_rng.s3 = i_cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rng       <= '{s1: SEED_RESET, s2: SEED_RESET, s3: SEED_RESET};
            r_sum       <= '0;
            r_counter   <= '0;
            r_mask_bits <= '0;
            r_full      <= 1'b0;
            r_p_valid   <= 1'b0;
            r_p_sel     <= 1'b0;
            r_p_idx     <= '0;
        end else begin
            r_rng     <= n_rng;
            r_sum     <= n_sum;
            r_p_valid <= i_cmd.issue;
            r_p_sel   <= r_full || sel_vec[i_idx];
            r_p_idx   <= i_idx;
            if (i_cmd.start) begin
                r_full <= (r_counter == '0);
            end
            if (i_cmd.load_out) begin
                r_counter <= r_counter + 1'b1;
            end
            if (i_cfg_valid && i_cfg_index == CFG_MASK_BITS) begin
                r_mask_bits <= i_cfg_data[MASK_W-1:0];
            end
        end
    end

    // Dice memory: one registered read and one write per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_rd_data <= r_dice[i_idx];
        end
        if (do_draw) begin
            r_dice[r_p_idx] <= new_die;
        end
    end

    assign mask   = {SAMPLE_W{1'b1}} << r_mask_bits;
    assign offset = (~mask) >> 1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_sample <= (r_sum & mask) + offset;
        end
    end

    assign o_sample = r_sample;

endmodule

`default_nettype wire

// ===== hdl/vpn_ctrl.sv =====
// Controller: walks the dice index once per sample and manages both handshakes.
// Depends on vpn_pkg; commands vpn_datapath.
`default_nettype none

module vpn_ctrl
    import vpn_pkg::*;
#(
    parameter int NUM_DICE = NUM_DICE_DEF,
    parameter int IDX_W    = $clog2(NUM_DICE)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_tick_valid,
    input  wire logic             i_tick,
    output logic                  o_tick_ready,
    output logic                  o_sample_valid,
    input  wire logic             i_sample_ready,
    output t_ctrl_cmd             o_cmd,
    output logic [IDX_W-1:0]      o_idx
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_DICE - 1);

    logic [1:0]       r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_tick_valid && i_tick) begin
                    o_cmd.start = 1'b1;
                    n_idx       = '0;
                    n_state     = S_RUN;
                end
            end
            S_RUN: begin
                o_cmd.issue = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_state = S_DRAIN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_DRAIN: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || i_sample_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_sample_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_tick_ready   = (r_state == S_IDLE);
    assign o_sample_valid = r_out_valid;
    assign o_idx          = r_idx;

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> r_out_valid)
        else $error("sample register not marked valid after load");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_sample_ready) |-> !o_cmd.load_out)
        else $error("pending sample overwritten");

    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && r_idx == LAST_IDX) |=> (r_state == S_DRAIN))
        else $error("dice walk did not end at the last die");

    a_start_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> (r_state == S_RUN && r_idx == '0))
        else $error("dice walk did not start at die zero");

endmodule

`default_nettype wire

// ===== hdl/voss_pink_noise_generator_top.sv =====
// Voss pink noise generator, top level: one sample for each tick beat with tick set.
// A tick beat is taken only while idle; the walk then runs through RUN, DRAIN and FIN, and FIN
// loads the output register once the previous sample is taken. One shared Tausworthe unit
// handles one die per cycle in RUN; the dice memory has a single read and a single write port.
// Reset: synchronous, active low; seeds load 12345, mask_bits clears, counter and sum clear.
// Depends on vpn_pkg, vpn_ctrl and vpn_datapath.
`default_nettype none

module voss_pink_noise_generator_top
    import vpn_pkg::*;
#(
    parameter int NUM_DICE     = NUM_DICE_DEF,
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Input channel: a tick beat with tick low is taken and yields nothing.
    input  wire logic                 i_tick_valid,
    output logic                      o_tick_ready,
    input  wire logic                 i_tick,
    // Output channel: one sample beat per tick beat with tick high.
    output logic                      o_sample_valid,
    input  wire logic                 i_sample_ready,
    output logic [SAMPLE_W-1:0]       o_sample,
    // Config channel, always ready; user must write only while the block is idle; unenforced.
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [WORD_W-1:0]    i_cfg_data
);

    localparam int IDX_W = $clog2(NUM_DICE);

    t_ctrl_cmd        cmd;
    logic [IDX_W-1:0] idx;

    // The controller walks every die index once per sample. The datapath reads the die
    // into a register, redraws it in the next cycle if the sample counter selects it (or
    // every die when the counter is zero) and updates the running sum by the difference.
    vpn_ctrl #(
        .NUM_DICE (NUM_DICE),
        .IDX_W    (IDX_W)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tick_valid   (i_tick_valid),
        .i_tick         (i_tick),
        .o_tick_ready   (o_tick_ready),
        .o_sample_valid (o_sample_valid),
        .i_sample_ready (i_sample_ready),
        .o_cmd          (cmd),
        .o_idx          (idx)
    );

    // The output register sits in the datapath, so a new tick beat is taken while the
    // previous sample still waits; the controller only stalls before overwriting it.
    vpn_datapath #(
        .NUM_DICE     (NUM_DICE),
        .COUNTER_BITS (COUNTER_BITS),
        .IDX_W        (IDX_W)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_idx       (idx),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_sample    (o_sample)
    );

    // Writes go straight into registers, so the configuration channel never back-pressures.
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for voss_pink_noise_generator_top: random tick and sample stalls,
// register phases, and an in-bench Voss/Taus88 predictor that checks every sample beat.
// Depends on vpn_pkg and the RTL of the generator.
`default_nettype none

module tb
    import vpn_pkg::*;
();

    // Cycles to let pass once the last sample is in.
    localparam int SETTLE_CYCLES = 40;
    // Cycles without any accepted beat on any channel before the run is declared hung.
    localparam int HANG_LIMIT    = 2000;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SLOW} t_rx_mode;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_tick_valid   = 1'b0;
    logic                 i_tick         = 1'b0;
    logic                 i_sample_ready = 1'b0;
    logic                 i_cfg_valid    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index    = CFG_MASK_BITS;
    logic [WORD_W-1:0]    i_cfg_data     = '0;
    logic                 o_tick_ready;
    logic                 o_sample_valid;
    logic [SAMPLE_W-1:0]  o_sample;
    logic                 o_cfg_ready;

    voss_pink_noise_generator_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tick_valid   (i_tick_valid),
        .o_tick_ready   (o_tick_ready),
        .i_tick         (i_tick),
        .o_sample_valid (o_sample_valid),
        .i_sample_ready (i_sample_ready),
        .o_sample       (o_sample),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Tick beats waiting to be sent, and samples predicted but not yet seen on the output.
    logic                pending_ticks[$];
    logic [SAMPLE_W-1:0] expected_samples[$];
    int                  fail_count = 0;

    // Predictor state: a private copy of the dice bank, the running sum, the sample counter,
    // the three Tausworthe words and the mask setting.
    logic [DIE_W-1:0]            dice[NUM_DICE_DEF];
    logic [SAMPLE_W-1:0]         dice_sum;
    logic [COUNTER_BITS_DEF-1:0] sample_count;
    t_taus                       taus_words;
    logic [MASK_W-1:0]           clear_bits;
    logic [SAMPLE_W-1:0]         want_sample;

    // One combined Taus88 step. Each component is written as the concatenation of its masked,
    // shifted-up state with the feedback bits, which land exactly in the zeroed low bits.
    function automatic logic [WORD_W-1:0] taus88_draw();
        taus_words.s1 = {taus_words.s1[19:1], taus_words.s1[18:6] ^ taus_words.s1[31:19]};
        taus_words.s2 = {taus_words.s2[27:3], taus_words.s2[29:23] ^ taus_words.s2[31:25]};
        taus_words.s3 = {taus_words.s3[14:4], taus_words.s3[28:8] ^ taus_words.s3[31:11]};
        return taus_words.s1 ^ taus_words.s2 ^ taus_words.s3;
    endfunction

    // Works out the sample for one tick and advances the predictor state.
    function automatic logic [SAMPLE_W-1:0] voss_next_sample();
        logic [SAMPLE_W-1:0] keep;
        logic [WORD_W-1:0]   word;
        if (sample_count == '0) begin
            // A zero counter rebuilds the whole bank, die 0 first.
            dice_sum = '0;
            for (int k = 0; k < NUM_DICE_DEF; k++) begin
                word    = taus88_draw();
                dice[k] = word[WORD_W-1:DIE_SHIFT];
                dice_sum = dice_sum + SAMPLE_W'(dice[k]);
            end
        end else begin
            // Otherwise each set counter bit rerolls its own die, in ascending order.
            for (int k = 0; k < COUNTER_BITS_DEF && k < NUM_DICE_DEF; k++) begin
                if (sample_count[k]) begin
                    word     = taus88_draw();
                    dice_sum = dice_sum - SAMPLE_W'(dice[k]);
                    dice[k]  = word[WORD_W-1:DIE_SHIFT];
                    dice_sum = dice_sum + SAMPLE_W'(dice[k]);
                end
            end
        end
        keep         = {SAMPLE_W{1'b1}} << clear_bits;
        sample_count = sample_count + 1'b1;
        return (dice_sum & keep) + ((~keep) >> 1);
    endfunction

    // Monitor: predicts on every accepted tick beat with tick high, follows register writes
    // and checks every sample beat against the oldest prediction. Values are sampled at the
    // edge, before the nonblocking updates of that edge land.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_bits   = '0;
            taus_words   = '{s1: SEED_RESET, s2: SEED_RESET, s3: SEED_RESET};
            dice_sum     = '0;
            sample_count = '0;
            for (int k = 0; k < NUM_DICE_DEF; k++) begin
                dice[k] = '0;
            end
            expected_samples.delete();
        end else begin
            if (o_sample_valid && i_sample_ready) begin
                if (expected_samples.size() == 0) begin
                    $error("sample: no sample expected, got %h", o_sample);
                    fail_count++;
                end else begin
                    want_sample = expected_samples.pop_front();
                    if (o_sample !== want_sample) begin
                        $error("sample: expected %h, got %h", want_sample, o_sample);
                        fail_count++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                // A seed write reloads its generator word at once.
                case (i_cfg_index)
                    CFG_MASK_BITS:  clear_bits    = i_cfg_data[MASK_W-1:0];
                    CFG_SEED_ONE:   taus_words.s1 = i_cfg_data;
                    CFG_SEED_TWO:   taus_words.s2 = i_cfg_data;
                    CFG_SEED_THREE: taus_words.s3 = i_cfg_data;
                    default: ;
                endcase
            end
            // A tick beat with tick low is consumed and yields nothing.
            if (i_tick_valid && o_tick_ready && i_tick) begin
                expected_samples.push_back(voss_next_sample());
            end
        end
    end

    // Tick driver: sends queued beats in bursts of random length, with random gaps between
    // bursts. Once raised, valid and the tick bit hold until the beat is taken.
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_tick_valid <= 1'b0;
            i_tick       <= 1'b0;
        end else if (!i_tick_valid || o_tick_ready) begin
            if (gap_left != 0 || pending_ticks.size() == 0) begin
                if (gap_left != 0) begin
                    gap_left--;
                end
                i_tick_valid <= 1'b0;
            end else begin
                i_tick_valid <= 1'b1;
                i_tick       <= pending_ticks.pop_front();
                if (burst_left != 0) begin
                    burst_left--;
                end
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    // Some bursts run straight into the next one.
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
                end
            end
        end
    end

    // Sample receiver: it switches at random between stall patterns of its own. Open takes every
    // beat, coin stalls at random, slow drops ready for long runs after each ready cycle.
    t_rx_mode rx_mode    = RX_OPEN;
    int       rx_cycles  = 0;
    int       stall_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_sample_ready <= 1'b0;
        end else begin
            rx_cycles++;
            if (rx_cycles % 256 == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 2));
            end
            if (stall_left != 0) begin
                stall_left--;
                i_sample_ready <= 1'b0;
            end else begin
                i_sample_ready <= (rx_mode != RX_COIN) || ($urandom_range(0, 1) == 1);
                if (rx_mode == RX_SLOW) begin
                    stall_left = $urandom_range(1, 60);
                end
            end
        end
    end

    // Watchdog: any accepted beat on any channel counts as progress.
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_tick_valid && o_tick_ready) || (o_sample_valid && i_sample_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= HANG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // One register write beat, launched on a rising edge and held until taken.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Waits until the sender is out of beats and every predicted sample is in, then lets the
    // block settle. Checks are made on falling edges, where all edge updates have landed.
    task automatic drain();
        do @(negedge i_clk);
        while (pending_ticks.size() != 0 || i_tick_valid || expected_samples.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Queues the low n bits of a pattern as tick beats, most significant first.
    task automatic queue_pattern(input logic [15:0] bits, input int n);
        for (int i = n - 1; i >= 0; i--) begin
            pending_ticks.push_back(bits[i]);
        end
    endtask

    // Queues n sampling ticks, with an idle tick slipped in now and then.
    task automatic queue_random(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 7) == 0) begin
                pending_ticks.push_back(1'b0);
            end
            pending_ticks.push_back(1'b1);
        end
    endtask

    // Seeds lean toward the extremes: tiny values (below each component's minimum too),
    // all ones, and otherwise anything.
    function automatic logic [WORD_W-1:0] pick_seed();
        case ($urandom_range(0, 5))
            0:       return WORD_W'($urandom_range(0, 20));
            1:       return {WORD_W{1'b1}};
            default: return $urandom();
        endcase
    endfunction

    // Mask setting in the low bits; the upper data bits are random and must be ignored.
    function automatic logic [WORD_W-1:0] pick_mask_word();
        logic [WORD_W-1:0] w;
        w = $urandom();
        case ($urandom_range(0, 3))
            0:       w[MASK_W-1:0] = '0;
            1:       w[MASK_W-1:0] = '1;
            default: w[MASK_W-1:0] = MASK_W'($urandom_range(0, 31));
        endcase
        return w;
    endfunction

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: an idle tick first, then the full rebuild on the first sample and
        // rerolls of the counter-selected dice after it, with idle ticks mixed in.
        queue_pattern(16'b0110_1111, 8);
        drain();

        // Widest mask and all-ones seeds.
        write_reg(CFG_MASK_BITS, WORD_W'(31));
        write_reg(CFG_SEED_ONE, {WORD_W{1'b1}});
        write_reg(CFG_SEED_TWO, {WORD_W{1'b1}});
        write_reg(CFG_SEED_THREE, {WORD_W{1'b1}});
        queue_pattern(16'b1_0111, 5);
        drain();

        // Seeds at or below each minimum: every component sticks at zero.
        write_reg(CFG_MASK_BITS, WORD_W'(1));
        write_reg(CFG_SEED_ONE, WORD_W'(0));
        write_reg(CFG_SEED_TWO, WORD_W'(7));
        write_reg(CFG_SEED_THREE, WORD_W'(15));
        queue_pattern(16'b1111, 4);
        drain();

        // All three components stuck at zero, a mid-range mask, and the narrowest mask last.
        write_reg(CFG_MASK_BITS, WORD_W'(16));
        write_reg(CFG_SEED_ONE, WORD_W'(1));
        write_reg(CFG_SEED_TWO, WORD_W'(0));
        write_reg(CFG_SEED_THREE, WORD_W'(0));
        queue_pattern(16'b111, 3);
        drain();
        write_reg(CFG_MASK_BITS, WORD_W'(0));
        write_reg(CFG_SEED_ONE, WORD_W'(2));
        write_reg(CFG_SEED_TWO, WORD_W'(8));
        write_reg(CFG_SEED_THREE, WORD_W'(16));
        queue_pattern(16'b111, 3);
        drain();

        // Random phases: a new mask each time, seeds reloaded now and then so the generators
        // also run on for long stretches. Each phase drains fully before the next writes.
        for (int phase = 0; phase < 8; phase++) begin
            write_reg(CFG_MASK_BITS, pick_mask_word());
            if ($urandom_range(0, 1) == 1) begin
                write_reg(CFG_SEED_ONE, pick_seed());
            end
            if ($urandom_range(0, 1) == 1) begin
                write_reg(CFG_SEED_TWO, pick_seed());
            end
            if ($urandom_range(0, 1) == 1) begin
                write_reg(CFG_SEED_THREE, pick_seed());
            end
            queue_random($urandom_range(70, 115));
            drain();
        end

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
hdl/vpn_pkg.sv
hdl/vpn_datapath.sv
hdl/vpn_ctrl.sv
hdl/voss_pink_noise_generator_top.sv
sim/tb.sv
